### src/assert_macros.svh
// Assertion helpers shared by pbd_decoder and pbd_burst. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define PBD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### src/pbd_pkg.sv
package pbd_pkg;

  localparam int LENGTH_BITS  = 24;
  localparam int BYTE_W       = 8;
  localparam int MAX_RESULTS  = 4;
  localparam int CNT_W        = 3;
  localparam int HEAD_BYTES   = 4;
  localparam int PREFIX_BYTES = 5;

  // Magic header, first byte in the lowest lane.
  localparam logic [HEAD_BYTES-1:0][BYTE_W-1:0] MAGIC = {8'hBE, 8'hBA, 8'hFE, 8'hCA};

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_PASS,
    MODE_DECODE,
    MODE_DRAIN
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_ZERO_STRIDE,
    ST_NEG_LEN
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    status_t           status;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] slot;
    logic    [CNT_W-1:0]       count;
  } bundle_t;

endpackage

### src/padded_blob_deobfuscator.sv
// Padded blob decoder. Blob bytes arrive one word per cycle on the in_ stream;
// the user must write the blob length through cfg_wr_en/cfg_wr_data only while
// the block is idle (the block has no check). A blob that opens with CA FE BA
// BE passes through unchanged. Any other blob is decoded: the filler count is
// byte0+byte1-byte2-byte3 (mod 256), byte4 is the stride, the block emits
// CA FE BA BE and then copies stride-byte chunks, dropping one filler byte
// after each, for at most filler-count chunks, and then copies the rest until
// length-5-filler content bytes are out. Short blobs, a zero stride and a
// negative content length each give one word with data zero, tlast set and
// the error code in tuser. Throughput is one input word per cycle while
// out_tready holds; the byte that completes the header (the fourth byte of a
// pass-through blob or the fifth byte of an encoded one) yields four output
// words, and the input then stalls while the four-slot output register drains.
// After reset the blob length is zero and no clearing pass is needed.
module padded_blob_deobfuscator
  import pbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Blob length register.
  input  logic                   cfg_wr_en,
  input  logic [LENGTH_BITS-1:0] cfg_wr_data,
  // Encoded blob input.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  // Decoded output.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [BYTE_W-1:0]      out_tdata,  // [7:0] out_byte
  output logic                   out_tlast,
  output logic [1:0]             out_tuser   // [1:0] status
);

  bundle_t bundle;
  result_t result;
  logic    step;

  // An input word is taken only when the output register can absorb its results.
  assign step = in_tvalid && in_tready;

  // Per-blob state and the decode decision for the current byte.
  pbd_decoder u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .data_byte   (in_tdata),
    .bundle      (bundle)
  );

  // Holds up to four result words; hands out one per cycle with out_tready high.
  pbd_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .bundle    (bundle),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = result.data;
  assign out_tlast = result.last;
  assign out_tuser = result.status;

endmodule

### src/pbd_decoder.sv
`include "assert_macros.svh"

module pbd_decoder
  import pbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LENGTH_BITS-1:0] cfg_wr_data,
  input  logic                   step,
  input  logic [BYTE_W-1:0]      data_byte,
  output bundle_t                bundle
);

  logic [LENGTH_BITS-1:0]               blob_length_r, blob_length_nxt;
  logic [HEAD_BYTES-1:0][BYTE_W-1:0]    lead_r, lead_nxt;
  logic [LENGTH_BITS-1:0]               index_r, index_nxt;
  logic [BYTE_W-1:0]                    filler_r, filler_nxt;
  logic [BYTE_W-1:0]                    stride_r, stride_nxt;
  logic [LENGTH_BITS-1:0]               content_r, content_nxt;
  logic [BYTE_W-1:0]                    chunk_pos_r, chunk_pos_nxt;
  logic [BYTE_W-1:0]                    chunks_done_r, chunks_done_nxt;
  logic [LENGTH_BITS-1:0]               emitted_r, emitted_nxt;
  mode_t                                mode_r, mode_nxt;

  logic [LENGTH_BITS:0]                 index_inc;
  logic                                 blob_end;
  logic [BYTE_W-1:0]                    filler_calc;
  logic [LENGTH_BITS:0]                 need;
  logic [LENGTH_BITS-1:0]               content_calc;
  logic                                 head_match;
  logic [LENGTH_BITS-1:0]               emitted_inc;
  logic                                 fin;
  logic                                 in_chunks;

  assign index_inc    = {1'b0, index_r} + (LENGTH_BITS+1)'(1);
  assign blob_end     = index_inc >= {1'b0, blob_length_r};
  assign filler_calc  = lead_r[0] + lead_r[1] - lead_r[2] - lead_r[3];
  assign need         = (LENGTH_BITS+1)'(filler_calc) + (LENGTH_BITS+1)'(PREFIX_BYTES);
  assign content_calc = LENGTH_BITS'({1'b0, blob_length_r} - need);
  assign head_match   = {data_byte, lead_r[2], lead_r[1], lead_r[0]} == MAGIC;
  assign emitted_inc  = emitted_r + LENGTH_BITS'(1);
  assign fin          = emitted_inc >= content_r;
  assign in_chunks    = chunks_done_r < filler_r;

  always_comb begin
    blob_length_nxt = cfg_wr_en ? cfg_wr_data : blob_length_r;
    lead_nxt        = lead_r;
    index_nxt       = index_r;
    filler_nxt      = filler_r;
    stride_nxt      = stride_r;
    content_nxt     = content_r;
    chunk_pos_nxt   = chunk_pos_r;
    chunks_done_nxt = chunks_done_r;
    emitted_nxt     = emitted_r;
    mode_nxt        = mode_r;
    bundle          = '0;

    if (step) begin
      unique case (mode_r)
        MODE_HEADER: begin
          if (index_r < LENGTH_BITS'(HEAD_BYTES)) begin
            lead_nxt[index_r[1:0]] = data_byte;
          end
          if (index_r == LENGTH_BITS'(HEAD_BYTES - 1)) begin
            if (head_match) begin
              mode_nxt = MODE_PASS;
              for (int i = 0; i < HEAD_BYTES; i++) begin
                bundle.slot[i].data   = (i == HEAD_BYTES - 1) ? data_byte : lead_r[i];
                bundle.slot[i].last   = (i == HEAD_BYTES - 1) && blob_end;
                bundle.slot[i].status = ST_OK;
              end
              bundle.count = CNT_W'(HEAD_BYTES);
            end else if (blob_end) begin
              bundle.slot[0].last   = 1'b1;
              bundle.slot[0].status = ST_SHORT;
              bundle.count          = CNT_W'(1);
            end
          end else if (index_r == LENGTH_BITS'(HEAD_BYTES)) begin
            filler_nxt = filler_calc;
            stride_nxt = data_byte;
            if ({1'b0, blob_length_r} < need) begin
              mode_nxt              = MODE_DRAIN;
              bundle.slot[0].last   = 1'b1;
              bundle.slot[0].status = ST_NEG_LEN;
              bundle.count          = CNT_W'(1);
            end else if (data_byte == '0) begin
              mode_nxt              = MODE_DRAIN;
              bundle.slot[0].last   = 1'b1;
              bundle.slot[0].status = ST_ZERO_STRIDE;
              bundle.count          = CNT_W'(1);
            end else begin
              content_nxt     = content_calc;
              chunk_pos_nxt   = '0;
              chunks_done_nxt = '0;
              emitted_nxt     = '0;
              mode_nxt        = (content_calc == '0) ? MODE_DRAIN : MODE_DECODE;
              for (int i = 0; i < HEAD_BYTES; i++) begin
                bundle.slot[i].data   = MAGIC[i];
                bundle.slot[i].last   = (i == HEAD_BYTES - 1) && (content_calc == '0);
                bundle.slot[i].status = ST_OK;
              end
              bundle.count = CNT_W'(HEAD_BYTES);
            end
          end else if (index_r < LENGTH_BITS'(HEAD_BYTES - 1) && blob_end) begin
            bundle.slot[0].last   = 1'b1;
            bundle.slot[0].status = ST_SHORT;
            bundle.count          = CNT_W'(1);
          end
        end
        MODE_PASS: begin
          bundle.slot[0].data   = data_byte;
          bundle.slot[0].last   = blob_end;
          bundle.slot[0].status = ST_OK;
          bundle.count          = CNT_W'(1);
        end
        MODE_DECODE: begin
          if (in_chunks && chunk_pos_r == stride_r) begin
            // Filler byte after a full chunk: drop it.
            chunk_pos_nxt   = '0;
            chunks_done_nxt = chunks_done_r + BYTE_W'(1);
          end else begin
            if (in_chunks) begin
              chunk_pos_nxt = chunk_pos_r + BYTE_W'(1);
            end
            emitted_nxt = emitted_inc;
            if (fin) begin
              mode_nxt = MODE_DRAIN;
            end
            bundle.slot[0].data   = data_byte;
            bundle.slot[0].last   = fin || blob_end;
            bundle.slot[0].status = ST_OK;
            bundle.count          = CNT_W'(1);
          end
        end
        MODE_DRAIN: begin
        end
        default: begin
        end
      endcase

      if (blob_end) begin
        index_nxt = '0;
        mode_nxt  = MODE_HEADER;
      end else begin
        index_nxt = index_inc[LENGTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blob_length_r <= '0;
      lead_r        <= '0;
      index_r       <= '0;
      filler_r      <= '0;
      stride_r      <= '0;
      content_r     <= '0;
      chunk_pos_r   <= '0;
      chunks_done_r <= '0;
      emitted_r     <= '0;
      mode_r        <= MODE_HEADER;
    end else begin
      blob_length_r <= blob_length_nxt;
      lead_r        <= lead_nxt;
      index_r       <= index_nxt;
      filler_r      <= filler_nxt;
      stride_r      <= stride_nxt;
      content_r     <= content_nxt;
      chunk_pos_r   <= chunk_pos_nxt;
      chunks_done_r <= chunks_done_nxt;
      emitted_r     <= emitted_nxt;
      mode_r        <= mode_nxt;
    end
  end

  `PBD_ASSERT_IMPL(a_pass_has_magic, mode_r == MODE_PASS, lead_r == MAGIC, "pass mode without magic header")
  `PBD_ASSERT_IMPL(a_decode_not_done, mode_r == MODE_DECODE, emitted_r < content_r, "decode past content length")
  `PBD_ASSERT_IMPL(a_chunk_in_range, mode_r == MODE_DECODE, chunk_pos_r <= stride_r, "chunk position beyond stride")

endmodule

### src/pbd_burst.sv
`include "assert_macros.svh"

module pbd_burst
  import pbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  bundle_t bundle,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  result_t [MAX_RESULTS-1:0] slot_r, slot_nxt;
  logic    [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                      out_fire;

  assign out_valid = cnt_r != '0;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);
  assign result    = slot_r[0];

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = bundle.slot;
      cnt_nxt  = bundle.count;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `PBD_ASSERT(a_cnt_range, cnt_r <= CNT_W'(MAX_RESULTS), "burst count out of range")
  `PBD_ASSERT_IMPL(a_load_when_free, load, (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_fire), "load over pending words")
  `PBD_ASSERT_IMPL(a_last_is_final, out_valid && result.last, cnt_r == CNT_W'(1), "last word not final in burst")

endmodule
